// File: rtl/tai_utc_offset_converter_assert.svh
// Assertion macros used by the converter's top-level RTL file.
// Each macro needs signals named clk and rst_n in the scope where it is used.
`ifndef TAI_UTC_OFFSET_CONVERTER_ASSERT_SVH
`define TAI_UTC_OFFSET_CONVERTER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define TUOC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define TUOC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: rtl/tuoc_pkg.sv
// Package for the TAI/UTC offset converter: sizes, leap-second ROM, ALU codes.
// No dependencies; every other RTL file but the assertion header imports it.
`default_nettype none

package tuoc_pkg;

    localparam int LEAP_TABLE_ENTRIES = 27;
    localparam int MAX_REFINE_PASSES  = 4;
    localparam int ROM_STEPS          = 27;
    localparam int SCAN_STEPS  = (LEAP_TABLE_ENTRIES < ROM_STEPS) ? LEAP_TABLE_ENTRIES : ROM_STEPS;
    localparam int SEARCH_BITS = $clog2(SCAN_STEPS + 1);
    localparam int BIT_W       = (SEARCH_BITS > 1) ? $clog2(SEARCH_BITS) : 1;
    localparam int PASS_W      = $clog2(MAX_REFINE_PASSES + 1);

    typedef logic [63:0] ns_t;

    localparam ns_t NS_IN_SEC  = 64'd1000000000;
    localparam ns_t SIGNED_MAX = {1'b0, {63{1'b1}}};
    localparam ns_t SIGNED_MIN = {1'b1, {63{1'b0}}};

    // Realtime start of each leap step in ns; step k sets the base to 11+k s.
    localparam ns_t LEAP_START_NS [ROM_STEPS] = '{
        64'd78796800 * NS_IN_SEC,   64'd94694400 * NS_IN_SEC,
        64'd126230400 * NS_IN_SEC,  64'd157766400 * NS_IN_SEC,
        64'd189302400 * NS_IN_SEC,  64'd220924800 * NS_IN_SEC,
        64'd252460800 * NS_IN_SEC,  64'd283996800 * NS_IN_SEC,
        64'd315532800 * NS_IN_SEC,  64'd362793600 * NS_IN_SEC,
        64'd394329600 * NS_IN_SEC,  64'd425865600 * NS_IN_SEC,
        64'd489024000 * NS_IN_SEC,  64'd567993600 * NS_IN_SEC,
        64'd631152000 * NS_IN_SEC,  64'd662688000 * NS_IN_SEC,
        64'd709948800 * NS_IN_SEC,  64'd741484800 * NS_IN_SEC,
        64'd773020800 * NS_IN_SEC,  64'd820454400 * NS_IN_SEC,
        64'd867715200 * NS_IN_SEC,  64'd915148800 * NS_IN_SEC,
        64'd1136073600 * NS_IN_SEC, 64'd1230768000 * NS_IN_SEC,
        64'd1341100800 * NS_IN_SEC, 64'd1435708800 * NS_IN_SEC,
        64'd1483228800 * NS_IN_SEC
    };

    // Request opcodes.
    localparam logic [1:0] OP_RT_TO_TAI = 2'd0;
    localparam logic [1:0] OP_TAI_TO_RT = 2'd1;
    localparam logic [1:0] OP_SET_TAI   = 2'd2;
    localparam logic [1:0] OP_UNUSED    = 2'd3;

    // Shared ALU operations.
    typedef logic [2:0] alu_op_t;
    localparam alu_op_t ALU_GE        = 3'd0;  // unsigned a >= b
    localparam alu_op_t ALU_SAT_ADD   = 3'd1;  // signed saturating a + b
    localparam alu_op_t ALU_APPLY     = 3'd2;  // unsigned a plus signed b, clamped
    localparam alu_op_t ALU_APPLY_NEG = 3'd3;  // unsigned a minus signed b, clamped
    localparam alu_op_t ALU_DIFF      = 3'd4;  // a - b, flag if beyond +-(2^63-1)
    localparam alu_op_t ALU_SUB_CHECK = 3'd5;  // signed a - b, flag below the signed minimum

    typedef struct packed {
        alu_op_t op;
        ns_t     a;
        ns_t     b;
    } alu_req_t;

    typedef struct packed {
        ns_t  result;
        logic flag;
    } alu_rsp_t;

    // Start time of one leap step; an index at or above SCAN_STEPS yields all ones.
    function automatic ns_t leap_start_ns(logic [SEARCH_BITS-1:0] idx);
        ns_t v;
        v = '1;
        for (int k = 0; k < SCAN_STEPS; k++) begin
            if (idx == SEARCH_BITS'(k))
            begin
                v = LEAP_START_NS[k];
            end
        end
        return v;
    endfunction

    // Base offset in ns once cnt leap steps have passed.
    function automatic ns_t base_ns(logic [SEARCH_BITS-1:0] cnt);
        return (64'(cnt) + 64'd10) * NS_IN_SEC;
    endfunction

endpackage

`default_nettype wire

// File: rtl/tuoc_if.sv
// Valid/ready channel interfaces for the converter's request and result items.
// Depends on tuoc_pkg for the time type.
`default_nettype none

interface tuoc_req_if;
    import tuoc_pkg::*;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    ns_t        realtime_in;
    ns_t        tai_in;

    modport source (output valid, output op, output realtime_in, output tai_in, input ready);
    modport sink   (input valid, input op, input realtime_in, input tai_in, output ready);
endinterface

interface tuoc_rsp_if;
    import tuoc_pkg::*;
    logic valid;
    logic ready;
    ns_t  time_out;
    logic status;

    modport source (output valid, output time_out, output status, input ready);
    modport sink   (input valid, input time_out, input status, output ready);
endinterface

`default_nettype wire

// File: rtl/tuoc_alu.sv
// Shared 66-bit add/compare unit with per-operation saturation and range flags.
// Depends on tuoc_pkg for opcodes and request/response structs.
`default_nettype none

module tuoc_alu
    import tuoc_pkg::*;
(
    input  alu_req_t req,
    output alu_rsp_t rsp
);

    logic [65:0] a_ext;
    logic [65:0] b_ext;
    logic        sub;
    logic [65:0] sum;

    // Operand extension and add/subtract select.
    always_comb
    begin
        a_ext = {2'b00, req.a};
        b_ext = {2'b00, req.b};
        sub   = 1'b0;
        case (req.op)
            ALU_GE, ALU_DIFF:
            begin
                sub = 1'b1;
            end
            ALU_SAT_ADD:
            begin
                a_ext = {{2{req.a[63]}}, req.a};
                b_ext = {{2{req.b[63]}}, req.b};
            end
            ALU_SUB_CHECK:
            begin
                a_ext = {{2{req.a[63]}}, req.a};
                b_ext = {{2{req.b[63]}}, req.b};
                sub   = 1'b1;
            end
            ALU_APPLY:
            begin
                b_ext = {{2{req.b[63]}}, req.b};
            end
            ALU_APPLY_NEG:
            begin
                // Negating the most negative offset saturates to the most positive.
                if (req.b == SIGNED_MIN)
                begin
                    b_ext = {2'b00, SIGNED_MAX};
                end
                else
                begin
                    b_ext = {{2{req.b[63]}}, req.b};
                    sub   = 1'b1;
                end
            end
            default:
            begin
                sub = 1'b0;
            end
        endcase
    end

    assign sum = a_ext + (sub ? ~b_ext : b_ext) + 66'(sub);

    // Result shaping: saturation and range flags.
    always_comb
    begin
        rsp.result = sum[63:0];
        rsp.flag   = 1'b0;
        case (req.op)
            ALU_GE:
            begin
                rsp.flag = ~sum[65];
            end
            ALU_SAT_ADD:
            begin
                if (sum[65] && (sum[64:63] != 2'b11))
                begin
                    rsp.result = SIGNED_MIN;
                end
                else if (!sum[65] && (sum[64:63] != 2'b00))
                begin
                    rsp.result = SIGNED_MAX;
                end
            end
            ALU_APPLY, ALU_APPLY_NEG:
            begin
                if (sum[65])
                begin
                    rsp.result = '0;
                end
                else if (sum[64])
                begin
                    rsp.result = '1;
                end
            end
            ALU_DIFF:
            begin
                // Distance must fit in 63 bits either way; -2^63 is out of range.
                if (!sum[65])
                begin
                    rsp.flag = (sum[64:63] != 2'b00);
                end
                else
                begin
                    rsp.flag = (sum[64:63] != 2'b11) || (sum[62:0] == '0);
                end
            end
            ALU_SUB_CHECK:
            begin
                rsp.flag = sum[65] && (sum[64:63] != 2'b11);
            end
            default:
            begin
                rsp.flag = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/tai_utc_offset_converter.sv
// Realtime-to-TAI runs the binary leap-table search, one saturating add and one offset
// application before the registered result; set-TAI takes the distance, the search and a
// range check, and a refused set distance or the unused op goes straight to the result.
// TAI-to-realtime repeats search, add and application: one initial pass and up to
// MAX_REFINE_PASSES more. A new item waits until the sequencer is idle.
// Reset clears the user offset to zero and empties the output register; no clearing pass.
`default_nettype none
`include "tai_utc_offset_converter_assert.svh"

module tai_utc_offset_converter
    import tuoc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    tuoc_req_if.sink     req,
    tuoc_rsp_if.source   rsp
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DIFF   = 3'd1;
    localparam logic [2:0] S_SEARCH = 3'd2;
    localparam logic [2:0] S_TOTAL  = 3'd3;
    localparam logic [2:0] S_APPLY  = 3'd4;
    localparam logic [2:0] S_CHECK  = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0]             state_reg,   state_next;
    logic [BIT_W-1:0]       bit_reg,     bit_next;
    logic [SEARCH_BITS-1:0] pos_reg,     pos_next;
    logic [PASS_W-1:0]      pass_reg,    pass_next;
    logic                   first_reg,   first_next;
    ns_t                    user_reg,    user_next;
    logic                   out_valid_reg, out_valid_next;

    logic [1:0] op_reg,      op_next;
    ns_t        rt_reg,      rt_next;
    ns_t        tai_reg,     tai_next;
    ns_t        key_reg,     key_next;
    ns_t        total_reg,   total_next;
    ns_t        guess_reg,   guess_next;
    ns_t        desired_reg, desired_next;
    ns_t        res_reg,     res_next;
    logic       status_reg,  status_next;
    ns_t        out_time_reg,   out_time_next;
    logic       out_status_reg, out_status_next;

    alu_req_t alu_req;
    alu_rsp_t alu_rsp;

    logic [SEARCH_BITS:0]   step;
    logic [SEARCH_BITS:0]   probe_sum;
    logic [SEARCH_BITS-1:0] probe_idx;
    logic                   probe_ok;
    logic [PASS_W-1:0]      pass_inc;
    logic                   out_free;

    tuoc_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    // Next probe of the binary search over the leap table.
    assign step      = (SEARCH_BITS + 1)'(1) << bit_reg;
    assign probe_sum = {1'b0, pos_reg} + step;
    assign probe_idx = SEARCH_BITS'(probe_sum - (SEARCH_BITS + 1)'(1));
    assign probe_ok  = probe_sum <= (SEARCH_BITS + 1)'(SCAN_STEPS);
    assign pass_inc  = pass_reg + PASS_W'(1);
    assign out_free  = !out_valid_reg || rsp.ready;

    assign req.ready    = (state_reg == S_IDLE);
    assign rsp.valid    = out_valid_reg;
    assign rsp.time_out = out_time_reg;
    assign rsp.status   = out_status_reg;

    // Operand routing into the shared ALU.
    always_comb
    begin
        alu_req.op = ALU_GE;
        alu_req.a  = '0;
        alu_req.b  = '0;
        case (state_reg)
            S_DIFF:
            begin
                alu_req.op = ALU_DIFF;
                alu_req.a  = tai_reg;
                alu_req.b  = rt_reg;
            end
            S_SEARCH:
            begin
                alu_req.op = ALU_GE;
                alu_req.a  = key_reg;
                alu_req.b  = leap_start_ns(probe_idx);
            end
            S_TOTAL:
            begin
                alu_req.op = ALU_SAT_ADD;
                alu_req.a  = base_ns(pos_reg);
                alu_req.b  = user_reg;
            end
            S_APPLY:
            begin
                alu_req.op = (op_reg == OP_RT_TO_TAI) ? ALU_APPLY : ALU_APPLY_NEG;
                alu_req.a  = (op_reg == OP_RT_TO_TAI) ? rt_reg : tai_reg;
                alu_req.b  = total_reg;
            end
            S_CHECK:
            begin
                alu_req.op = ALU_SUB_CHECK;
                alu_req.a  = desired_reg;
                alu_req.b  = base_ns(pos_reg);
            end
            default:
            begin
                alu_req.op = ALU_GE;
            end
        endcase
    end

    // Sequencer.
    always_comb
    begin
        state_next      = state_reg;
        bit_next        = bit_reg;
        pos_next        = pos_reg;
        pass_next       = pass_reg;
        first_next      = first_reg;
        user_next       = user_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        op_next         = op_reg;
        rt_next         = rt_reg;
        tai_next        = tai_reg;
        key_next        = key_reg;
        total_next      = total_reg;
        guess_next      = guess_reg;
        desired_next    = desired_reg;
        res_next        = res_reg;
        status_next     = status_reg;
        out_time_next   = out_time_reg;
        out_status_next = out_status_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next     = req.op;
                    rt_next     = req.realtime_in;
                    tai_next    = req.tai_in;
                    key_next    = req.realtime_in;
                    pos_next    = '0;
                    bit_next    = BIT_W'(SEARCH_BITS - 1);
                    pass_next   = '0;
                    first_next  = 1'b1;
                    res_next    = '0;
                    status_next = 1'b0;
                    case (req.op)
                        OP_RT_TO_TAI, OP_TAI_TO_RT: state_next = S_SEARCH;
                        OP_SET_TAI:                 state_next = S_DIFF;
                        default:                    state_next = S_DONE;
                    endcase
                end
            end
            S_DIFF:
            begin
                // Desired user offset before the base is taken off.
                desired_next = alu_rsp.result;
                if (alu_rsp.flag)
                begin
                    status_next = 1'b1;
                    state_next  = S_DONE;
                end
                else
                begin
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                if (probe_ok && alu_rsp.flag)
                begin
                    pos_next = SEARCH_BITS'(probe_sum);
                end
                if (bit_reg == '0)
                begin
                    state_next = (op_reg == OP_SET_TAI) ? S_CHECK : S_TOTAL;
                end
                else
                begin
                    bit_next = bit_reg - BIT_W'(1);
                end
            end
            S_TOTAL:
            begin
                total_next = alu_rsp.result;
                state_next = S_APPLY;
            end
            S_APPLY:
            begin
                pos_next = '0;
                bit_next = BIT_W'(SEARCH_BITS - 1);
                key_next = alu_rsp.result;
                if (op_reg == OP_RT_TO_TAI)
                begin
                    res_next   = alu_rsp.result;
                    state_next = S_DONE;
                end
                else if (first_reg)
                begin
                    // Initial guess from the current realtime.
                    guess_next = alu_rsp.result;
                    first_next = 1'b0;
                    state_next = S_SEARCH;
                end
                else if ((alu_rsp.result == guess_reg) ||
                         (pass_inc == PASS_W'(MAX_REFINE_PASSES)))
                begin
                    res_next   = alu_rsp.result;
                    state_next = S_DONE;
                end
                else
                begin
                    guess_next = alu_rsp.result;
                    pass_next  = pass_inc;
                    state_next = S_SEARCH;
                end
            end
            S_CHECK:
            begin
                if (alu_rsp.flag)
                begin
                    status_next = 1'b1;
                end
                else
                begin
                    user_next = alu_rsp.result;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_time_next   = res_reg;
                    out_status_next = status_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state and the stored user offset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            bit_reg       <= '0;
            pos_reg       <= '0;
            pass_reg      <= '0;
            first_reg     <= 1'b0;
            user_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bit_reg       <= bit_next;
            pos_reg       <= pos_next;
            pass_reg      <= pass_next;
            first_reg     <= first_next;
            user_reg      <= user_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        rt_reg         <= rt_next;
        tai_reg        <= tai_next;
        key_reg        <= key_next;
        total_reg      <= total_next;
        guess_reg      <= guess_next;
        desired_reg    <= desired_next;
        res_reg        <= res_next;
        status_reg     <= status_next;
        out_time_reg   <= out_time_next;
        out_status_reg <= out_status_next;
    end

    // An error result never carries a time.
    `TUOC_ASSERT_NOW(a_status_zero_time, out_valid_reg && out_status_reg, out_time_reg == '0)
    // The user offset only moves in the range-check step.
    `TUOC_ASSERT_NEXT(a_user_stable, state_reg != S_CHECK, user_reg == $past(user_reg))
    // The search never counts past the scanned part of the table.
    `TUOC_ASSERT_NOW(a_pos_bound, 1'b1, pos_reg <= SEARCH_BITS'(SCAN_STEPS))
    // Refinement stops within the pass limit.
    `TUOC_ASSERT_NOW(a_pass_bound, 1'b1, pass_reg < PASS_W'(MAX_REFINE_PASSES))

endmodule

`default_nettype wire
